@@ src/bap_pkg.sv @@
// shared types and constants of the box average image pyramid
package bap_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_OCTAVES = 8;

    localparam int LVL_W   = $clog2(MAX_OCTAVES);
    localparam int COL_W   = 10;
    localparam int ROW_W   = 10;
    localparam int DIM_W   = 11;
    localparam int OCT_W   = 4;
    localparam int PIX_W   = 8;
    localparam int SUM_W   = PIX_W + 1;
    localparam int LINE_AW = $clog2(MAX_WIDTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 2'd2;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [OCT_W-1:0] OCTAVE_RESET = 4'd4;

    typedef struct packed {
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic [OCT_W-1:0] octave_count;
        logic             restart;
    } bap_cfg_t;

    typedef struct packed {
        logic [2:0]       octave;
        logic [PIX_W-1:0] value;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             last_in_run;
    } bap_result_t;

endpackage

@@ src/bap_channels.sv @@
// valid/ready channel interfaces for source pixels and pyramid results
interface bap_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface bap_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] octave;
    logic [7:0] value;
    logic [9:0] column;
    logic [9:0] row;
    logic       last_in_run;

    modport source (output valid, output octave, output value, output column,
                    output row, output last_in_run, input ready);
    modport sink (input valid, input octave, input value, input column,
                  input row, input last_in_run, output ready);
endinterface

@@ src/bap_cascade.sv @@
// per-level cascade sequencer with the pair-sum line memory
module bap_cascade (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bap_pkg::bap_cfg_t          cfg,
    input  logic                       in_valid,
    input  logic [bap_pkg::PIX_W-1:0]  in_pixel,
    output logic                       in_ready,
    input  logic                       advance,
    output logic                       res_valid,
    output bap_pkg::bap_result_t       res
);
    import bap_pkg::*;

    // current level being emitted
    logic               cur_valid_reg, cur_valid_next;
    logic [LVL_W-1:0]   cur_lvl_reg, cur_lvl_next;
    logic               cur_from_mem_reg, cur_from_mem_next;
    logic [PIX_W-1:0]   cur_pix_reg, cur_pix_next;
    logic [SUM_W-1:0]   cur_sum_reg, cur_sum_next;
    logic [DIM_W-1:0]   cur_w_reg, cur_w_next;
    logic [DIM_W-1:0]   cur_h_reg, cur_h_next;
    logic [LINE_AW-1:0] cur_off_reg, cur_off_next;

    // per-level state
    logic [PIX_W-1:0]   held_reg [MAX_OCTAVES];
    logic [COL_W-1:0]   col_reg  [MAX_OCTAVES];
    logic [ROW_W-1:0]   row_reg  [MAX_OCTAVES];

    // line memory, one read or write per cycle
    logic [SUM_W-1:0]   line_mem [MAX_WIDTH];
    logic [SUM_W-1:0]   rd_data_reg;

    logic [COL_W-1:0]   c;
    logic [ROW_W-1:0]   r;
    logic [SUM_W:0]     avg_sum;
    logic [PIX_W-1:0]   p;
    logic [DIM_W-2:0]   w2, h2;
    logic               deeper, in_block, more, step;
    logic               c_wrap, r_wrap;
    logic [SUM_W-1:0]   s;
    logic [LINE_AW-1:0] idx;
    logic               mem_we, mem_re;
    logic [DIM_W-1:0]   off_sum;

    always_comb
    begin
        c        = col_reg[cur_lvl_reg];
        r        = row_reg[cur_lvl_reg];
        avg_sum  = {1'b0, rd_data_reg} + {1'b0, cur_sum_reg};
        p        = cur_from_mem_reg ? avg_sum[SUM_W:2] : cur_pix_reg;
        w2       = cur_w_reg[DIM_W-1:1];
        h2       = cur_h_reg[DIM_W-1:1];
        deeper   = ({1'b0, cur_lvl_reg} + {{LVL_W{1'b0}}, 1'b1}) < cfg.octave_count;
        in_block = deeper && (w2 != '0) && (h2 != '0)
                   && ({1'b0, c} < {w2, 1'b0}) && ({1'b0, r} < {h2, 1'b0});
        more     = in_block && c[0] && r[0];
        step     = cur_valid_reg && advance;
        c_wrap   = ({1'b0, c} + {{COL_W{1'b0}}, 1'b1}) >= cur_w_reg;
        r_wrap   = ({1'b0, r} + {{ROW_W{1'b0}}, 1'b1}) >= cur_h_reg;
        s        = {1'b0, held_reg[cur_lvl_reg]} + {1'b0, p};
        idx      = cur_off_reg + {1'b0, c[COL_W-1:1]};
        mem_we   = step && in_block && c[0] && !r[0];
        mem_re   = step && more;
        off_sum  = {1'b0, cur_off_reg} + {1'b0, w2};
    end

    assign in_ready  = !cur_valid_reg || (advance && !more);
    assign res_valid = cur_valid_reg;

    always_comb
    begin
        res.octave      = 3'(cur_lvl_reg);
        res.value       = p;
        res.column      = c;
        res.row         = r;
        res.last_in_run = !more;
    end

    always_comb
    begin
        cur_valid_next    = cur_valid_reg;
        cur_lvl_next      = cur_lvl_reg;
        cur_from_mem_next = cur_from_mem_reg;
        cur_pix_next      = cur_pix_reg;
        cur_sum_next      = cur_sum_reg;
        cur_w_next        = cur_w_reg;
        cur_h_next        = cur_h_reg;
        cur_off_next      = cur_off_reg;
        if (step && more)
        begin
            cur_lvl_next      = cur_lvl_reg + {{(LVL_W-1){1'b0}}, 1'b1};
            cur_from_mem_next = 1'b1;
            cur_sum_next      = s;
            cur_w_next        = {1'b0, w2};
            cur_h_next        = {1'b0, h2};
            cur_off_next      = off_sum[LINE_AW-1:0];
        end
        else if (in_valid && in_ready)
        begin
            cur_valid_next    = 1'b1;
            cur_lvl_next      = '0;
            cur_from_mem_next = 1'b0;
            cur_pix_next      = in_pixel;
            cur_w_next        = cfg.image_width;
            cur_h_next        = cfg.image_height;
            cur_off_next      = '0;
        end
        else if (step)
        begin
            cur_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_lvl_reg      <= cur_lvl_next;
        cur_from_mem_reg <= cur_from_mem_next;
        cur_pix_reg      <= cur_pix_next;
        cur_sum_reg      <= cur_sum_next;
        cur_w_reg        <= cur_w_next;
        cur_h_reg        <= cur_h_next;
        cur_off_reg      <= cur_off_next;
    end

    // position counters and held left pixels, cleared on frame restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_OCTAVES; i++)
            begin
                held_reg[i] <= '0;
                col_reg[i]  <= '0;
                row_reg[i]  <= '0;
            end
        end
        else if (cfg.restart)
        begin
            for (int i = 0; i < MAX_OCTAVES; i++)
            begin
                held_reg[i] <= '0;
                col_reg[i]  <= '0;
                row_reg[i]  <= '0;
            end
        end
        else if (step)
        begin
            if (c_wrap)
            begin
                col_reg[cur_lvl_reg] <= '0;
                row_reg[cur_lvl_reg] <= r_wrap ? '0 : r + {{(ROW_W-1){1'b0}}, 1'b1};
            end
            else
            begin
                col_reg[cur_lvl_reg] <= c + {{(COL_W-1){1'b0}}, 1'b1};
            end
            if (in_block && !c[0])
            begin
                held_reg[cur_lvl_reg] <= p;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[idx] <= s;
        end
        if (mem_re)
        begin
            rd_data_reg <= line_mem[idx];
        end
    end

endmodule

@@ src/box_average_image_pyramid.sv @@
// top level: configuration registers, cascade sequencer and result register
// order: a pixel is taken into the sequencer's current-level registers, its result
// word then into the output register; each deeper octave of the same pixel follows
// throughput: one result word per cycle while results are not stalled; a pixel
// has one to octave_count results (about four thirds on average)
// reset: rst_n clears all position counters, held pixels and word valids and
// loads 640 x 480 with four octaves; the line memory is not cleared
module box_average_image_pyramid (
    input  logic                              clk,
    input  logic                              rst_n,
    bap_pixel_if.sink                         pixels,
    bap_result_if.source                      results,
    input  logic                              cfg_write,
    input  logic [bap_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bap_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bap_pkg::*;

    // configuration registers
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [OCT_W-1:0] octaves_reg, octaves_next;
    logic             cfg_hit;

    // output register decouples the result side from the sequencer
    logic             out_valid_reg;
    bap_result_t      out_word_reg;
    logic             out_take;

    bap_cfg_t         cfg;
    logic             res_valid;
    bap_result_t      res;

    // saturate written values into their legal ranges
    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        octaves_next = octaves_reg;
        cfg_hit      = 1'b0;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    cfg_hit = 1'b1;
                    if (cfg_data < DIM_W'(2))
                        width_next = DIM_W'(2);
                    else if (cfg_data > DIM_W'(MAX_WIDTH))
                        width_next = DIM_W'(MAX_WIDTH);
                    else
                        width_next = cfg_data;
                end
                CFG_IMAGE_HEIGHT:
                begin
                    cfg_hit = 1'b1;
                    if (cfg_data < DIM_W'(2))
                        height_next = DIM_W'(2);
                    else if (cfg_data > DIM_W'(MAX_HEIGHT))
                        height_next = DIM_W'(MAX_HEIGHT);
                    else
                        height_next = cfg_data;
                end
                CFG_OCTAVE_COUNT:
                begin
                    cfg_hit = 1'b1;
                    if (cfg_data[OCT_W-1:0] < OCT_W'(1))
                        octaves_next = OCT_W'(1);
                    else if (cfg_data[OCT_W-1:0] > OCT_W'(MAX_OCTAVES))
                        octaves_next = OCT_W'(MAX_OCTAVES);
                    else
                        octaves_next = cfg_data[OCT_W-1:0];
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            octaves_reg <= OCTAVE_RESET;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            octaves_reg <= octaves_next;
        end
    end

    // any accepted register write restarts the frame
    always_comb
    begin
        cfg.image_width  = width_reg;
        cfg.image_height = height_reg;
        cfg.octave_count = octaves_reg;
        cfg.restart      = cfg_hit;
    end

    // sequencer advances whenever the output register can take a word
    assign out_take = !out_valid_reg || results.ready;

    bap_cascade u_cascade (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (pixels.valid),
        .in_pixel  (pixels.pixel),
        .in_ready  (pixels.ready),
        .advance   (out_take),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && res_valid)
        begin
            out_word_reg <= res;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.octave      = out_word_reg.octave;
    assign results.value       = out_word_reg.value;
    assign results.column      = out_word_reg.column;
    assign results.row         = out_word_reg.row;
    assign results.last_in_run = out_word_reg.last_in_run;

endmodule

@@ bench/testbench.sv @@
// self-checking bench for the box average image pyramid: directed table, then random frames
`timescale 1ns / 1ps

module testbench;
    import bap_pkg::*;

    // settle time before a register write and drain time at the end, in cycles
    // (a result word passes the sequencer and output registers, deeper octaves follow)
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 8;
    localparam int RUN_LIMIT_NS  = 600000;

    // index past the register list, the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_kind_t;

    // one row of the directed table: a pixel word or a register write,
    // with the expected word typed in where it is obvious
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  data;
        logic [PIX_W-1:0]       pixel;
        logic                   typed;
        bap_result_t            want;
    } stim_row_t;

    localparam bap_result_t NO_WORD = '0;
    localparam int DIRECTED_ROWS = 28;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // reset geometry 640 x 480: first two pixels echo only
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b1, '{3'd0, 8'd0, 10'd0, 10'd0, 1'b1}},
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b1, '{3'd0, 8'd255, 10'd1, 10'd0, 1'b1}},
        // below-range sizes clamp to 2 x 2, octave count 15 clamps to 8
        '{ROW_CONFIG, CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, NO_WORD},
        '{ROW_CONFIG, CFG_IMAGE_HEIGHT, 11'd1,    8'd0,   1'b0, NO_WORD},
        '{ROW_CONFIG, CFG_OCTAVE_COUNT, 11'h7ff,  8'd0,   1'b0, NO_WORD},
        // full-scale 2 x 2 block, average saturates at the top
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b0, NO_WORD},
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b0, NO_WORD},
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b0, NO_WORD},
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b0, NO_WORD},
        // truncating block, with a write to an unused index mid frame
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, NO_WORD},
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b0, NO_WORD},
        '{ROW_CONFIG, CFG_UNUSED_INDEX, 11'd5,    8'd0,   1'b0, NO_WORD},
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b0, NO_WORD},
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, NO_WORD},
        // above-range sizes clamp to 1024, octave count 0 clamps to 1
        '{ROW_CONFIG, CFG_IMAGE_WIDTH,  11'h7ff,  8'd0,   1'b0, NO_WORD},
        '{ROW_CONFIG, CFG_IMAGE_HEIGHT, 11'h7ff,  8'd0,   1'b0, NO_WORD},
        '{ROW_CONFIG, CFG_OCTAVE_COUNT, 11'd0,    8'd0,   1'b0, NO_WORD},
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd1,   1'b1, '{3'd0, 8'd1, 10'd0, 10'd0, 1'b1}},
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd254, 1'b0, NO_WORD},
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd128, 1'b0, NO_WORD},
        // 3 x 3 with two octaves: trailing column is dropped
        '{ROW_CONFIG, CFG_IMAGE_WIDTH,  11'd3,    8'd0,   1'b0, NO_WORD},
        '{ROW_CONFIG, CFG_IMAGE_HEIGHT, 11'd3,    8'd0,   1'b0, NO_WORD},
        '{ROW_CONFIG, CFG_OCTAVE_COUNT, 11'd2,    8'd0,   1'b0, NO_WORD},
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd10,  1'b0, NO_WORD},
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd20,  1'b0, NO_WORD},
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd250, 1'b0, NO_WORD},
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd30,  1'b0, NO_WORD},
        '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  11'd0,    8'd40,  1'b0, NO_WORD}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bap_pixel_if  pixel_ch ();
    bap_result_if result_ch ();

    box_average_image_pyramid u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixel_ch),
        .results   (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // pyramid predictor state: geometry, held left pixels, pair-sum line, counters
    int unsigned      img_w = WIDTH_RESET;
    int unsigned      img_h = HEIGHT_RESET;
    int unsigned      oct_n = OCTAVE_RESET;
    logic [PIX_W-1:0] held_left [MAX_OCTAVES];
    logic [SUM_W-1:0] pair_sums [MAX_WIDTH];
    int unsigned      lvl_col [MAX_OCTAVES];
    int unsigned      lvl_row [MAX_OCTAVES];

    // pyramid words still to come out, oldest first
    bap_result_t expected_words [$];

    int unsigned mismatches = 0;
    bit          idle_on = 1'b1;

    function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic void restart_frame();
        for (int k = 0; k < MAX_OCTAVES; k++)
        begin
            held_left[k] = '0;
            lvl_col[k]   = 0;
            lvl_row[k]   = 0;
        end
    endfunction

    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IMAGE_WIDTH:  img_w = clamp(data, 2, MAX_WIDTH);
            CFG_IMAGE_HEIGHT: img_h = clamp(data, 2, MAX_HEIGHT);
            CFG_OCTAVE_COUNT: oct_n = clamp(data[OCT_W-1:0], 1, MAX_OCTAVES);
            default:          return;
        endcase
        restart_frame();
    endfunction

    // cascade of one pixel: echo at octave 0, then each completed 2x2 block
    // feeds the next octave, lowest octave first
    function automatic void predict_pixel(logic [PIX_W-1:0] px);
        int unsigned      lvl;
        int unsigned      off;
        int unsigned      w;
        int unsigned      h;
        int unsigned      w2;
        int unsigned      h2;
        int unsigned      c;
        int unsigned      r;
        int unsigned      s;
        int unsigned      idx;
        logic [PIX_W-1:0] p;
        bit               more;
        bap_result_t      word;
        lvl = 0;
        off = 0;
        p   = px;
        do
        begin
            w    = img_w >> lvl;
            h    = img_h >> lvl;
            c    = lvl_col[lvl];
            r    = lvl_row[lvl];
            more = 1'b0;
            word.octave = lvl[2:0];
            word.value  = p;
            word.column = c[COL_W-1:0];
            word.row    = r[ROW_W-1:0];
            // advance this level's raster position, wrapping at frame end
            if (c + 1 >= w)
            begin
                lvl_col[lvl] = 0;
                lvl_row[lvl] = (r + 1 >= h) ? 0 : r + 1;
            end
            else
            begin
                lvl_col[lvl] = c + 1;
            end
            if (lvl + 1 < oct_n)
            begin
                w2 = w >> 1;
                h2 = h >> 1;
                // an empty next level or an odd trailing row/column adds nothing
                if (w2 != 0 && h2 != 0 && c < 2 * w2 && r < 2 * h2)
                begin
                    if (!c[0])
                    begin
                        held_left[lvl] = p;
                    end
                    else
                    begin
                        s   = held_left[lvl] + p;
                        idx = off + (c >> 1);
                        if (idx < MAX_WIDTH)
                        begin
                            if (!r[0])
                            begin
                                pair_sums[idx] = s[SUM_W-1:0];
                            end
                            else
                            begin
                                p    = PIX_W'((pair_sums[idx] + s) >> 2);
                                more = 1'b1;
                            end
                        end
                    end
                end
                off += w2;
            end
            word.last_in_run = !more;
            expected_words.push_back(word);
            lvl++;
        end
        while (more);
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly small sizes and legal octave counts, now and then any 11-bit value
    function automatic logic [CFG_DATA_W-1:0] pick_setting(logic [CFG_IDX_W-1:0] idx);
        if ($urandom_range(0, 7) == 0)
        begin
            return CFG_DATA_W'($urandom_range(0, 2047));
        end
        if (idx == CFG_OCTAVE_COUNT)
        begin
            return CFG_DATA_W'($urandom_range(1, MAX_OCTAVES));
        end
        return CFG_DATA_W'($urandom_range(2, 14));
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // register write, only once every expected word is out
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        pixel_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        apply_setting(idx, data);
    endtask

    // offer one pixel word, optionally after an idle burst, and predict on accept
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic typed,
                              input bap_result_t want);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.pixel <= px;
        do
        begin
            @(posedge clk);
        end
        while (!pixel_ch.ready);
        predict_pixel(px);
        // typed rows carry their own single expected word
        if (typed)
        begin
            expected_words[expected_words.size() - 1] = want;
        end
    endtask

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

    // result side: ready high for stretches, with stall bursts while idle_on is set
    initial
    begin
        result_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // every accepted result word is matched against the oldest expectation
    always @(posedge clk)
    begin
        bap_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: octave %0d column %0d row %0d",
                       result_ch.octave, result_ch.column, result_ch.row);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("octave", want.octave, result_ch.octave);
                check_field("value", want.value, result_ch.value);
                check_field("column", want.column, result_ch.column);
                check_field("row", want.row, result_ch.row);
                check_field("last_in_run", want.last_in_run, result_ch.last_in_run);
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [CFG_IDX_W-1:0] reg_order [3];
        int unsigned          random_items;
        int unsigned          order;
        int unsigned          frame;
        int unsigned          count;
        reg_order[0] = CFG_IMAGE_WIDTH;
        reg_order[1] = CFG_IMAGE_HEIGHT;
        reg_order[2] = CFG_OCTAVE_COUNT;
        random_items = 0;
        restart_frame();

        // all inputs known from time zero, reset held low, then released
        rst_n          <= 1'b0;
        pixel_ch.valid <= 1'b0;
        pixel_ch.pixel <= '0;
        cfg_write      <= 1'b0;
        cfg_index      <= CFG_IMAGE_WIDTH;
        cfg_data       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_CONFIG)
            begin
                write_reg(DIRECTED[i].index, DIRECTED[i].data);
            end
            else
            begin
                send_pixel(DIRECTED[i].pixel, DIRECTED[i].typed, DIRECTED[i].want);
            end
        end

        // one full 8 x 8 frame at eight octaves: four-deep cascade, then an empty level
        write_reg(CFG_IMAGE_WIDTH, 11'd8);
        write_reg(CFG_IMAGE_HEIGHT, 11'd8);
        write_reg(CFG_OCTAVE_COUNT, 11'd8);
        repeat (64) send_pixel(random_pixel(), 1'b0, NO_WORD);

        // random geometries, registers written in a rotating order, one to one
        // and a half frames each, capped at 90 pixels, so small frames cross the wrap
        while (random_items < 60)
        begin
            order = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++)
            begin
                write_reg(reg_order[(order + k) % 3], pick_setting(reg_order[(order + k) % 3]));
            end
            if ($urandom_range(0, 5) == 0)
            begin
                write_reg(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom_range(0, 2047)));
            end
            frame = img_w * img_h;
            count = frame + $urandom_range(0, frame / 2);
            if (count > 90)
            begin
                count = 90;
            end
            repeat (count) send_pixel(random_pixel(), 1'b0, NO_WORD);
            random_items += count;
        end

        // last stretch at full rate on both sides
        idle_on = 1'b0;
        write_reg(CFG_IMAGE_WIDTH, 11'd7);
        write_reg(CFG_IMAGE_HEIGHT, 11'd6);
        write_reg(CFG_OCTAVE_COUNT, 11'd4);
        repeat (42) send_pixel(random_pixel(), 1'b0, NO_WORD);
        pixel_ch.valid <= 1'b0;

        // drain: wait for every expected word, then a few more cycles
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (END_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/bap_pkg.sv
src/bap_channels.sv
src/bap_cascade.sv
src/box_average_image_pyramid.sv
bench/testbench.sv
